/* hdl/tsov_pkg.sv */
// Shared types and constants for the triple sensor outlier voter.
package tsov_pkg;

  localparam logic [10:0] THR_MIN       = 11'd128;
  localparam logic [10:0] THR_MAX       = 11'd1280;
  localparam logic [15:0] CONF_ONE      = 16'd32768;
  localparam logic [15:0] CONF_DEGRADED = 16'd9830;
  localparam logic [14:0] RECIP3        = 15'd21845;
  localparam int          DIV_STEPS     = 24;
  localparam int          QUEUE_DEPTH   = 4;
  localparam logic        ADDR_THR      = 1'b0;
  localparam logic        ADDR_WEN      = 1'b1;

  typedef struct packed {
    logic [2:0][23:0] x;
    logic [2:0][15:0] c;
    logic [25:0]      s;
    logic [1:0]       p;
    logic [1:0]       sec;
  } tsov_base_t;

  typedef struct packed {
    tsov_base_t  b;
    logic [51:0] q;
    logic [2:0]  outl;
  } tsov_item_t;

endpackage

/* hdl/tsov_front.sv */
// Front pipeline: statistics, source ranking and outlier classification.
module tsov_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0][23:0]       in_x,
  input  logic [2:0][15:0]       in_c,
  input  logic [10:0]            thr,
  output logic                   push,
  output tsov_pkg::tsov_item_t   push_item,
  input  logic                   q_full
);
  import tsov_pkg::*;

  logic [5:0]        v_r, v_nxt;
  logic              en;
  logic [2:0][23:0]  x0_r;
  logic [2:0][15:0]  c0_r;
  tsov_base_t        b1_r, b2_r, b3_r, b4_r, b1_nxt;
  logic [2:0][25:0]  adev1_r, adev1_nxt;
  logic [20:0]       tt1_r, tt2_r, tt3_r, tt1_nxt;
  logic [2:0][50:0]  sq2_r, sq2_nxt;
  logic [51:0]       q3_r, q4_r, q3_nxt;
  logic [2:0][68:0]  lhs3_r, lhs4_r, lhs3_nxt;
  logic [46:0]       plo4_r, phi4_r;
  tsov_item_t        item5_r, item5_nxt;
  logic [26:0]       xe, d, nd;
  logic [10:0]       thc;
  logic [21:0]       ttw;
  logic [51:0]       sqw;
  logic [72:0]       rhs;
  logic [1:0]        p, sec;

  assign en        = !(v_r[5] && q_full);
  assign in_ready  = en;
  assign push      = v_r[5] && !q_full;
  assign push_item = item5_r;
  assign v_nxt     = {v_r[4:0], in_valid};

  always_comb begin
    b1_nxt.x = x0_r;
    b1_nxt.c = c0_r;
    b1_nxt.s = {{2{x0_r[0][23]}}, x0_r[0]} + {{2{x0_r[1][23]}}, x0_r[1]}
             + {{2{x0_r[2][23]}}, x0_r[2]};
    xe = '0;
    d  = '0;
    nd = '0;
    for (int i = 0; i < 3; i++) begin
      xe = {{3{x0_r[i][23]}}, x0_r[i]};
      d  = (xe << 1) + xe - {b1_nxt.s[25], b1_nxt.s};
      nd = -d;
      adev1_nxt[i] = d[26] ? nd[25:0] : d[25:0];
    end
    if (thr < THR_MIN) begin
      thc = THR_MIN;
    end else if (thr > THR_MAX) begin
      thc = THR_MAX;
    end else begin
      thc = thr;
    end
    ttw     = 22'(thc) * 22'(thc);
    tt1_nxt = ttw[20:0];
    p = 2'd0;
    if (c0_r[1] > c0_r[p]) p = 2'd1;
    if (c0_r[2] > c0_r[p]) p = 2'd2;
    sec = (p == 2'd0) ? 2'd1 : 2'd0;
    if (p != 2'd2 && c0_r[2] > c0_r[sec]) sec = 2'd2;
    if (p == 2'd2 && sec == 2'd0 && c0_r[1] > c0_r[0]) sec = 2'd1;
    b1_nxt.p   = p;
    b1_nxt.sec = sec;
  end

  always_comb begin
    sqw = '0;
    for (int i = 0; i < 3; i++) begin
      sqw        = {26'd0, adev1_r[i]} * {26'd0, adev1_r[i]};
      sq2_nxt[i] = sqw[50:0];
    end
    q3_nxt = {1'b0, sq2_r[0]} + {1'b0, sq2_r[1]} + {1'b0, sq2_r[2]};
    for (int i = 0; i < 3; i++) begin
      lhs3_nxt[i] = {1'b0, sq2_r[i], 17'd0} + {2'b0, sq2_r[i], 16'd0};
    end
    rhs = 73'(plo4_r) + (73'(phi4_r) << 26);
    item5_nxt.b = b4_r;
    item5_nxt.q = q4_r;
    for (int i = 0; i < 3; i++) begin
      item5_nxt.outl[i] = (q4_r != 52'd0) && (73'(lhs4_r[i]) > rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= in_x;
      c0_r    <= in_c;
      b1_r    <= b1_nxt;
      adev1_r <= adev1_nxt;
      tt1_r   <= tt1_nxt;
      b2_r    <= b1_r;
      sq2_r   <= sq2_nxt;
      tt2_r   <= tt1_r;
      b3_r    <= b2_r;
      q3_r    <= q3_nxt;
      lhs3_r  <= lhs3_nxt;
      tt3_r   <= tt2_r;
      b4_r    <= b3_r;
      q4_r    <= q3_r;
      lhs4_r  <= lhs3_r;
      plo4_r  <= 47'(tt3_r) * 47'(q3_r[25:0]);
      phi4_r  <= 47'(tt3_r) * 47'(q3_r[51:26]);
      item5_r <= item5_nxt;
    end
  end

endmodule

/* hdl/tsov_queue.sv */
// Short queue of classified items between the front and back pipelines.
module tsov_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tsov_pkg::tsov_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output tsov_pkg::tsov_item_t head_item
);
  import tsov_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  tsov_item_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

/* hdl/tsov_back.sv */
// Back pipeline: vote selection, shared divider and square root, output register.
module tsov_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  tsov_pkg::tsov_item_t head_item,
  output logic                 pop,
  input  logic                 wen,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [23:0]          out_alt,
  output logic [15:0]          out_conf,
  output logic [1:0]           out_p,
  output logic [1:0]           out_sec,
  output logic [22:0]          out_spread
);
  import tsov_pkg::*;

  typedef struct packed {
    logic [42:0] rem;
    logic [23:0] quot;
    logic        neg;
    logic [17:0] den;
    logic        use_div;
    logic [23:0] alt;
    logic [15:0] conf;
    logic [1:0]  p;
    logic [1:0]  sec;
    logic [51:0] qrem;
    logic [23:0] root;
  } tsov_stage_t;

  logic               en;
  logic               v0_r, v1_r;
  logic [DIV_STEPS:0] sv_r;
  tsov_item_t         it0_r, it1_r;
  logic signed [40:0] prod_r [3];
  logic signed [40:0] prod_nxt [3];
  logic [17:0]        sc1_r, sc_w;
  logic [16:0]        qg1_r;
  logic [32:0]        scm;
  tsov_stage_t        st_r [DIV_STEPS+1];
  tsov_stage_t        st0_nxt, fin;
  logic               out_valid_r;
  logic [23:0]        out_alt_r, alt_fin, nq;
  logic [15:0]        out_conf_r;
  logic [1:0]         out_p_r, out_sec_r;
  logic [22:0]        out_spread_r;

  logic [2:0]         surv;
  logic [1:0]         nsurv;
  logic [42:0]        sx, sall, num, nnum;
  logic [17:0]        sw, aw, r3;
  logic [16:0]        conf3;
  logic [16:0]        confw;
  logic [25:0]        lo, hi, xs, med;
  logic [23:0]        one_x;
  logic [15:0]        one_c;

  assign en         = !(out_valid_r && !out_ready);
  assign pop        = en && head_valid;
  assign out_valid  = out_valid_r;
  assign out_alt    = out_alt_r;
  assign out_conf   = out_conf_r;
  assign out_p      = out_p_r;
  assign out_sec    = out_sec_r;
  assign out_spread = out_spread_r;

  always_comb begin
    sc_w = '0;
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = $signed(it0_r.b.x[i]) * $signed({1'b0, it0_r.b.c[i]});
      if (!it0_r.outl[i]) sc_w = sc_w + 18'(it0_r.b.c[i]);
    end
    scm = 33'(sc_w) * 33'(RECIP3);
  end

  always_comb begin
    surv  = ~it1_r.outl;
    nsurv = 2'($countones(surv));
    sx    = '0;
    sall  = '0;
    sw    = '0;
    aw    = '0;
    one_x = '0;
    one_c = '0;
    for (int i = 2; i >= 0; i--) begin
      sall = sall + {{2{prod_r[i][40]}}, prod_r[i]};
      aw   = aw + 18'(it1_r.b.c[i]);
      if (surv[i]) begin
        sx    = sx + {{2{prod_r[i][40]}}, prod_r[i]};
        sw    = sw + 18'(it1_r.b.c[i]);
        one_x = it1_r.b.x[i];
        one_c = it1_r.b.c[i];
      end
    end
    r3    = sc1_r - 18'(qg1_r) - 18'(qg1_r) - 18'(qg1_r);
    conf3 = (r3 >= 18'd3) ? qg1_r + 17'd1 : qg1_r;
    lo = {{2{it1_r.b.x[0][23]}}, it1_r.b.x[0]};
    hi = lo;
    for (int i = 1; i < 3; i++) begin
      xs = {{2{it1_r.b.x[i][23]}}, it1_r.b.x[i]};
      if ($signed(xs) < $signed(lo)) lo = xs;
      if ($signed(xs) > $signed(hi)) hi = xs;
    end
    med = it1_r.b.s - lo - hi;
    st0_nxt      = '0;
    st0_nxt.p    = it1_r.b.p;
    st0_nxt.sec  = it1_r.b.sec;
    st0_nxt.qrem = it1_r.q;
    num          = {{17{it1_r.b.s[25]}}, it1_r.b.s};
    st0_nxt.den  = 18'd3;
    case (nsurv)
      2'd3, 2'd2: begin
        st0_nxt.use_div = 1'b1;
        confw = (nsurv == 2'd3) ? conf3 : sc1_r[17:1];
        if (sw != 18'd0) begin
          num         = sx;
          st0_nxt.den = sw;
        end else if (wen && aw != 18'd0) begin
          num         = sall;
          st0_nxt.den = aw;
        end
      end
      2'd1: begin
        st0_nxt.alt = one_x;
        confw       = 17'(one_c);
      end
      default: begin
        st0_nxt.alt = med[23:0];
        confw       = 17'(CONF_DEGRADED);
      end
    endcase
    st0_nxt.conf = (confw > 17'(CONF_ONE)) ? CONF_ONE : confw[15:0];
    nnum         = -num;
    st0_nxt.neg  = num[42];
    st0_nxt.rem  = num[42] ? nnum : num;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    localparam int K = DIV_STEPS - 1 - g;
    logic [42:0] dv;
    logic [53:0] tr, dl;
    tsov_stage_t nx;

    always_comb begin
      nx = st_r[g];
      dv = 43'(st_r[g].den) << K;
      if (st_r[g].rem >= dv) begin
        nx.rem     = st_r[g].rem - dv;
        nx.quot[K] = 1'b1;
      end
      tr = (54'(st_r[g].root) << (K + 1)) + (54'(1) << (2 * K));
      dl = (tr << 4) + (tr << 3) + (tr << 1) + tr;
      if (dl <= 54'(st_r[g].qrem)) begin
        nx.qrem    = st_r[g].qrem - dl[51:0];
        nx.root[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g+1] <= nx;
      end
    end
  end

  always_comb begin
    fin     = st_r[DIV_STEPS];
    nq      = -fin.quot;
    alt_fin = fin.use_div ? (fin.neg ? nq : fin.quot) : fin.alt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= head_valid;
      v1_r        <= v0_r;
      sv_r        <= {sv_r[DIV_STEPS-1:0], v1_r};
      out_valid_r <= sv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0_r        <= head_item;
      it1_r        <= it0_r;
      prod_r       <= prod_nxt;
      sc1_r        <= sc_w;
      qg1_r        <= scm[32:16];
      st_r[0]      <= st0_nxt;
      out_alt_r    <= alt_fin;
      out_conf_r   <= fin.conf;
      out_p_r      <= fin.p;
      out_sec_r    <= fin.sec;
      out_spread_r <= fin.root[23] ? 23'h7FFFFF : fin.root[22:0];
    end
  end

endmodule

/* hdl/triple_sensor_outlier_voter_core.sv */
// Top level of the triple sensor outlier voter with its register port.
//
//  channel   ports                              transaction moves
//  input     in_valid / in_ready / in_*         three altitudes and confidences
//  result    out_valid / out_ready / out_*      consensus, sources, spread
//  config    psel penable pwrite paddr pwdata   threshold and weighting mode
//
// One transaction per clock unless the result stalls. Path: 6 front stages,
// the queue, 3 select stages, 24 divider and root stages (one bit each), output.
// Reset is synchronous, active low, and empties every stage and the queue.
// A stalled result holds the back pipeline; the front holds when the queue fills.
module triple_sensor_outlier_voter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_accel_altitude,
  input  logic [23:0] in_baro_altitude,
  input  logic [23:0] in_gps_altitude,
  input  logic [15:0] in_accel_confidence,
  input  logic [15:0] in_baro_confidence,
  input  logic [15:0] in_gps_confidence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_consensus_altitude,
  output logic [15:0] out_consensus_confidence,
  output logic [1:0]  out_primary_source,
  output logic [1:0]  out_secondary_source,
  output logic [22:0] out_spread,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsov_pkg::*;

  logic [10:0]      thr_r;
  logic             wen_r;
  logic             push, q_full, pop, head_valid;
  tsov_item_t       push_item, head_item;
  logic [2:0][23:0] xs;
  logic [2:0][15:0] cs;

  assign xs     = {in_gps_altitude, in_baro_altitude, in_accel_altitude};
  assign cs     = {in_gps_confidence, in_baro_confidence, in_accel_confidence};
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_WEN) ? {31'd0, wen_r} : {21'd0, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 11'd512;
      wen_r <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ADDR_THR) begin
        thr_r <= pwdata[10:0];
      end else begin
        wen_r <= pwdata[0];
      end
    end
  end

  tsov_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (xs),
    .in_c      (cs),
    .thr       (thr_r),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  tsov_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tsov_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .wen        (wen_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_alt    (out_consensus_altitude),
    .out_conf   (out_consensus_confidence),
    .out_p      (out_primary_source),
    .out_sec    (out_secondary_source),
    .out_spread (out_spread)
  );

endmodule

/* hdl/tsov_checker.sv */
// Port-level checker for the voter core and its bind.
module tsov_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_consensus_altitude,
  input logic [15:0] out_consensus_confidence,
  input logic [1:0]  out_primary_source,
  input logic [1:0]  out_secondary_source,
  input logic [22:0] out_spread
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_consensus_altitude)
      && $stable(out_spread))
    else $error("result changed while stalled");

  a_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_primary_source != out_secondary_source
      && out_primary_source != 2'd3 && out_secondary_source != 2'd3)
    else $error("bad source ranking");

  a_conf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_consensus_confidence <= 16'd32768)
    else $error("confidence above one");

  a_hold_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_consensus_confidence)
      && $stable(out_primary_source) && $stable(out_secondary_source))
    else $error("result sources or confidence changed while stalled");

endmodule

bind triple_sensor_outlier_voter_core tsov_checker u_tsov_checker (.*);

/* tb/tb_triple_sensor_outlier_voter_core.sv */
// Testbench for the triple sensor outlier voter: random and directed triples checked against a predictor.
module tb_triple_sensor_outlier_voter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tsov_pkg::*;

  typedef struct {
    logic [23:0] alt [3];
    logic [15:0] conf [3];
  } triple_t;

  typedef struct {
    logic [23:0] alt;
    logic [15:0] conf;
    logic [1:0]  primary;
    logic [1:0]  secondary;
    logic [22:0] spread;
  } vote_t;

  class vote_board;
    vote_t       pending_votes [$];
    logic [10:0] threshold = 11'd512;
    logic        weighted = 1'b1;
    int          mismatches = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic vote_t vote_of(triple_t t);
      longint          x [3];
      longint          c [3];
      longint unsigned dev [3];
      bit              outl [3];
      longint          s, sx, sw, sc, lo, hi, res_alt, res_conf, aw;
      longint unsigned q, thr;
      logic [127:0]    lhs, rhs;
      int              surv, p, sec;
      vote_t           v;
      s = 0;
      q = 0;
      for (int i = 0; i < 3; i++) begin
        x[i] = longint'($signed(t.alt[i]));
        c[i] = longint'(t.conf[i]);
        s += x[i];
      end
      for (int i = 0; i < 3; i++) begin
        dev[i] = (3 * x[i] - s < 0) ? -(3 * x[i] - s) : 3 * x[i] - s;
        q += dev[i] * dev[i];
      end
      thr = threshold;
      if (thr < THR_MIN) thr = THR_MIN;
      if (thr > THR_MAX) thr = THR_MAX;
      surv = 0;
      for (int i = 0; i < 3; i++) begin
        lhs = 128'(dev[i] * dev[i]) * 128'd196608;
        rhs = 128'(thr * thr) * 128'(q);
        outl[i] = (q != 0) && (lhs > rhs);
        if (!outl[i]) surv++;
      end
      res_alt = 0;
      res_conf = 0;
      if (surv >= 2) begin
        sx = 0;
        sw = 0;
        sc = 0;
        for (int i = 0; i < 3; i++) begin
          if (!outl[i]) begin
            sx += x[i] * c[i];
            sw += c[i];
            sc += c[i];
          end
        end
        res_conf = sc / surv;
        aw = c[0] + c[1] + c[2];
        if (sw > 0) res_alt = sx / sw;
        else if (weighted && aw > 0) res_alt = (x[0] * c[0] + x[1] * c[1] + x[2] * c[2]) / aw;
        else res_alt = s / 3;
      end else if (surv == 1) begin
        for (int i = 2; i >= 0; i--) begin
          if (!outl[i]) begin
            res_alt = x[i];
            res_conf = c[i];
          end
        end
      end else begin
        lo = x[0];
        hi = x[0];
        for (int i = 1; i < 3; i++) begin
          if (x[i] < lo) lo = x[i];
          if (x[i] > hi) hi = x[i];
        end
        res_alt = s - lo - hi;
        res_conf = CONF_DEGRADED;
      end
      if (res_conf > CONF_ONE) res_conf = CONF_ONE;
      p = 0;
      for (int i = 1; i < 3; i++) if (c[i] > c[p]) p = i;
      sec = -1;
      for (int i = 0; i < 3; i++) begin
        if (i != p && (sec < 0 || c[i] > c[sec])) sec = i;
      end
      v.alt = res_alt[23:0];
      v.conf = res_conf[15:0];
      v.primary = p[1:0];
      v.secondary = sec[1:0];
      q = floor_sqrt(q / 27);
      v.spread = (q > 64'h7FFFFF) ? 23'h7FFFFF : q[22:0];
      return v;
    endfunction

    function void note_triple(triple_t t);
      pending_votes.push_back(vote_of(t));
    endfunction

    function void check_vote(vote_t got);
      vote_t exp_v;
      if (pending_votes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: alt %0d", got.alt);
        return;
      end
      exp_v = pending_votes.pop_front();
      if (exp_v.alt !== got.alt || exp_v.conf !== got.conf || exp_v.primary !== got.primary
          || exp_v.secondary !== got.secondary || exp_v.spread !== got.spread) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp alt %0d conf %0d src %0d/%0d spread %0d, got alt %0d conf %0d src %0d/%0d spread %0d",
                   $signed(exp_v.alt), exp_v.conf, exp_v.primary, exp_v.secondary, exp_v.spread,
                   $signed(got.alt), got.conf, got.primary, got.secondary, got.spread);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_accel_altitude = '0, in_baro_altitude = '0, in_gps_altitude = '0;
  logic [15:0] in_accel_confidence = '0, in_baro_confidence = '0, in_gps_confidence = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_consensus_altitude;
  logic [15:0] out_consensus_confidence;
  logic [1:0]  out_primary_source, out_secondary_source;
  logic [22:0] out_spread;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vote_board board = new();
  bit        quiet = 1'b0;
  bit        long_hold = 1'b0;
  int        idle_cycles = 0;

  triple_sensor_outlier_voter_core uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    triple_t t;
    vote_t   r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        t.alt = '{in_accel_altitude, in_baro_altitude, in_gps_altitude};
        t.conf = '{in_accel_confidence, in_baro_confidence, in_gps_confidence};
        board.note_triple(t);
      end
      if (out_valid && out_ready) begin
        r.alt = out_consensus_altitude;
        r.conf = out_consensus_confidence;
        r.primary = out_primary_source;
        r.secondary = out_secondary_source;
        r.spread = out_spread;
        board.check_vote(r);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (1) begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ADDR_THR) board.threshold = val[10:0];
    else board.weighted = val[0];
  endtask

  task automatic send_triple(triple_t t);
    in_valid <= 1'b1;
    in_accel_altitude <= t.alt[0];
    in_baro_altitude <= t.alt[1];
    in_gps_altitude <= t.alt[2];
    in_accel_confidence <= t.conf[0];
    in_baro_confidence <= t.conf[1];
    in_gps_confidence <= t.conf[2];
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_direct(int a, int b, int g, int ca, int cb, int cg);
    triple_t t;
    t.alt = '{a[23:0], b[23:0], g[23:0]};
    t.conf = '{ca[15:0], cb[15:0], cg[15:0]};
    send_triple(t);
  endtask

  task automatic send_random();
    triple_t t;
    longint  base, v;
    int      kind, odd;
    kind = $urandom_range(0, 9);
    base = longint'($signed(24'($urandom)));
    odd = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      if (kind < 2) v = longint'($signed(24'($urandom)));
      else if (kind == 8) v = base;
      else if (kind == 9) v = (i == 0) ? base + $urandom_range(0, 50) : base;
      else if (i == odd) v = base + longint'($urandom_range(0, 200000)) - 100000;
      else v = base + longint'($urandom_range(0, 40)) - 20;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      t.alt[i] = v[23:0];
      case ($urandom_range(0, 7))
        0: t.conf[i] = '0;
        1: t.conf[i] = 16'($urandom);
        2: t.conf[i] = CONF_ONE;
        default: t.conf[i] = 16'($urandom_range(0, 32768));
      endcase
    end
    if ($urandom_range(0, 9) == 0) t.conf = '{16'd0, 16'd0, 16'd0};
    send_triple(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_votes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    logic [10:0] thr_set [6];
    logic        wen_set [6];
    thr_set = '{11'd512, 11'd128, 11'd1280, 11'd0, 11'd2047, 11'($urandom_range(0, 2047))};
    wen_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom)};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ADDR_THR, 32'(thr_set[ph]));
      write_reg(ADDR_WEN, 32'(wen_set[ph]));
      if (ph == 0) begin
        send_direct(8388607, 8388607, 8388607, 32768, 32768, 32768);
        send_direct(-8388608, -8388608, -8388608, 0, 0, 0);
        send_direct(8388607, -8388608, 0, 65535, 65535, 65535);
        send_direct(-8388608, 8388607, 8388607, 1, 32768, 32767);
        send_direct(1234, 1234, 1234, 100, 200, 300);
        send_direct(1000, 1001, 50000, 30000, 20000, 10000);
        send_direct(1000, 1001, 50000, 0, 0, 32768);
        send_direct(1000, 1001, 50000, 0, 0, 0);
        send_direct(-500, 7000, -499, 16384, 16384, 16384);
        send_direct(0, 1, 3, 5, 5, 0);
        send_direct(10, 20, 30, 65535, 0, 65535);
        send_direct(-1, 0, 1, 32768, 32768, 0);
        send_direct(4000000, -4000000, 12, 40000, 50000, 60000);
        send_direct(0, 0, 8388607, 0, 1, 0);
        send_direct(100, 100, 100, 0, 0, 0);
        send_direct(-8388608, 8388607, -8388608, 32768, 0, 32768);
      end
      if (ph == 1) long_hold = 1'b1;
      for (int n = 0; n < 73; n++) begin
        if (ph == 5 && n == 13) quiet = 1'b1;
        send_random();
      end
      drain();
    end
    if (board.mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
